FILE: design/ncvi_pkg.sv
// ----------------------------------------------------------------------------
// ncvi_pkg: shared types and constants for the note to control value unit
// Field widths, opcodes, table access structs and the constant dividers
// used to split a note into octave and pitch class.
// ----------------------------------------------------------------------------
`default_nettype none

package ncvi_pkg;

  localparam int OpW    = 2;
  localparam int ChanW  = 5;
  localparam int SlotW  = 4;
  localparam int PcW    = 4;
  localparam int DataW  = 16;
  localparam int NoteW  = 7;
  localparam int FracW  = 8;
  localparam int OctW   = 4;
  localparam int GlideW = 13;
  localparam int TuneW  = DataW + 1;

  localparam int PITCH_CLASSES = 12;

  // note / 12 == (note * 171) >> 11 for every 7-bit note
  localparam int Div12Recip = 171;
  localparam int Div12Shift = 11;
  // x / 3 == (x * 43691) >> 17 for x below 2^16
  localparam int Div3Recip  = 43691;

  typedef logic [OpW-1:0] opcode_t;
  localparam opcode_t OP_WR_OCTAVE = 2'd0;
  localparam opcode_t OP_WR_TUNE   = 2'd1;
  localparam opcode_t OP_COMPUTE   = 2'd2;

  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] slot;
    logic [ChanW-1:0] ch;
    logic [DataW-1:0] data;
  } oct_wr_t;

  typedef struct packed {
    logic             en;
    logic [ChanW-1:0] ch;
    logic [OctW-1:0]  oct_a;
    logic [OctW-1:0]  oct_b;
  } oct_rd_t;

  function automatic logic [OctW-1:0] oct_of_note(input logic [NoteW-1:0] note);
    logic [14:0] p;
    p = 15'(note) * 15'(Div12Recip);
    return p[Div12Shift +: OctW];
  endfunction

  // (frac * 256) / 12 == (frac * 64) / 3
  function automatic logic [GlideW-1:0] glide_offset(input logic [FracW-1:0] frac);
    logic [13:0] x;
    logic [29:0] p;
    x = {frac, 6'b0};
    p = 30'(x) * 30'(Div3Recip);
    return p[29:17];
  endfunction

endpackage

`default_nettype wire

FILE: design/ncvi_octave_mem.sv
// ----------------------------------------------------------------------------
// ncvi_octave_mem: per-octave, per-channel calibration table
// One write port, two read ports with registered data. Out of range writes
// are dropped; a read on an out of range channel returns zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ncvi_octave_mem
  import ncvi_pkg::*;
#(
  parameter int OCTAVE_COUNT  = 11,
  parameter int CHANNEL_COUNT = 18
) (
  input  wire logic             clk,
  input  wire oct_wr_t          wr,
  input  wire oct_rd_t          rd,
  output logic [DataW-1:0]      rd_a_data,
  output logic [DataW-1:0]      rd_b_data
);

  localparam int Depth = OCTAVE_COUNT * CHANNEL_COUNT;
  localparam int AddrW = $clog2(Depth);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] q_a_r, q_b_r;
  logic             ch_ok_r;

  logic             wr_ok;
  logic             rd_ch_ok;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr_a;
  logic [AddrW-1:0] rd_addr_b;

  always_comb begin
    wr_ok    = wr.en && (32'(wr.slot) < OCTAVE_COUNT) && (32'(wr.ch) < CHANNEL_COUNT);
    rd_ch_ok = 32'(rd.ch) < CHANNEL_COUNT;
    wr_addr  = AddrW'(32'(wr.slot) * CHANNEL_COUNT + 32'(wr.ch));
    if (rd_ch_ok) begin
      rd_addr_a = AddrW'(32'(rd.oct_a) * CHANNEL_COUNT + 32'(rd.ch));
      rd_addr_b = AddrW'(32'(rd.oct_b) * CHANNEL_COUNT + 32'(rd.ch));
    end else begin
      rd_addr_a = '0;
      rd_addr_b = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= wr.data;
    end
    if (rd.en) begin
      q_a_r   <= mem[rd_addr_a];
      q_b_r   <= mem[rd_addr_b];
      ch_ok_r <= rd_ch_ok;
    end
  end

  assign rd_a_data = ch_ok_r ? q_a_r : '0;
  assign rd_b_data = ch_ok_r ? q_b_r : '0;

endmodule

`default_nettype wire

FILE: design/note_to_cv_interpolator_unit.sv
// ----------------------------------------------------------------------------
// note_to_cv_interpolator_unit: note number to control value converter
// Piecewise linear interpolation over a per-octave calibration table with
// per-pitch-class tuning, linear extrapolation above the table.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per transfer; in_tuser carries the opcode. Table writes
//           (octave entry or pitch-class tuning) finish in the transfer cycle
//           and give no result. A compute item gives one result on out_*.
//   out_* : control value and per-octave span, held in an output register.
//   Timing: a write completes at its transfer edge. A compute item runs
//           through the table read at the transfer edge, then the octave
//           value and extrapolation, the interpolation multiply and the
//           output load. in_tready returns high on the edge that loads
//           out_tvalid, so the next item can transfer once the result is loaded.
//           The sequence is set by the two-port table read followed by two
//           dependent multiply stages; one item is in flight at a time.
//   Stall:  a pending result waits in the output register while the next
//           item is taken; a second result holds in the final state until
//           the output register frees up.
//   Reset:  rst_n clears control state only; both tables hold garbage
//           until written and must be loaded before use.
// ----------------------------------------------------------------------------
`default_nettype none

module note_to_cv_interpolator_unit
  import ncvi_pkg::*;
#(
  parameter int OCTAVE_COUNT  = 11,
  parameter int CHANNEL_COUNT = 18
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [4:0] channel, [8:5] octave_slot, [12:9] pitch_class, [28:13] entry_data,
  // [35:29] note_number, [43:36] glide_fraction, [47:44] zero
  input  wire logic [47:0] in_tdata,
  // [1:0] opcode
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [15:0] control_value, [31:16] per_octave_span
  output logic [31:0]      out_tdata
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_MUL  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // input unpacking
  opcode_t          op;
  logic [ChanW-1:0] channel;
  logic [SlotW-1:0] octave_slot;
  logic [PcW-1:0]   pitch_class;
  logic [DataW-1:0] entry_data;
  logic [NoteW-1:0] note_number;
  logic [FracW-1:0] glide_fraction;

  assign op             = in_tuser;
  assign channel        = in_tdata[4:0];
  assign octave_slot    = in_tdata[8:5];
  assign pitch_class    = in_tdata[12:9];
  assign entry_data     = in_tdata[28:13];
  assign note_number    = in_tdata[35:29];
  assign glide_fraction = in_tdata[43:36];

  logic in_xfer;
  logic cmp_start;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign cmp_start = in_xfer && (op == OP_COMPUTE);

  // note split and read addressing
  logic [OctW-1:0] note_oct;
  logic [OctW:0]   hi_oct;
  logic [PcW-1:0]  note_pc;
  logic            extrap;
  logic [OctW-1:0] k_lo;

  always_comb begin
    note_oct = oct_of_note(note_number);
    hi_oct   = {1'b0, note_oct} + (OctW+1)'(1);
    note_pc  = PcW'(note_number - NoteW'(32'(note_oct) * PITCH_CLASSES));
    extrap   = 32'(hi_oct) >= OCTAVE_COUNT;
    k_lo     = extrap ? OctW'(32'(hi_oct) - OCTAVE_COUNT) : '0;
  end

  oct_wr_t oct_wr;
  oct_rd_t oct_rd;
  logic [DataW-1:0] rd_a, rd_b;

  always_comb begin
    oct_wr.en   = in_xfer && (op == OP_WR_OCTAVE);
    oct_wr.slot = octave_slot;
    oct_wr.ch   = channel;
    oct_wr.data = entry_data;
    oct_rd.en   = cmp_start;
    oct_rd.ch   = channel;
    // above the table, fetch the last two entries for extrapolation
    oct_rd.oct_a = extrap ? OctW'(OCTAVE_COUNT - 2) : note_oct;
    oct_rd.oct_b = extrap ? OctW'(OCTAVE_COUNT - 1) : hi_oct[OctW-1:0];
  end

  ncvi_octave_mem #(
    .OCTAVE_COUNT  (OCTAVE_COUNT),
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_octave_mem (
    .clk       (clk),
    .wr        (oct_wr),
    .rd        (oct_rd),
    .rd_a_data (rd_a),
    .rd_b_data (rd_b)
  );

  // pitch-class tuning memory
  logic [DataW-1:0]  tune_mem [PITCH_CLASSES];
  logic [DataW-1:0]  tune_q_r;
  logic [GlideW-1:0] glide_r;
  logic              extrap_r;
  logic [OctW-1:0]   k_lo_r;

  always_ff @(posedge clk) begin
    if (in_xfer && (op == OP_WR_TUNE) && (32'(pitch_class) < PITCH_CLASSES)) begin
      tune_mem[pitch_class] <= entry_data;
    end
    if (cmp_start) begin
      tune_q_r <= tune_mem[note_pc];
      glide_r  <= glide_offset(glide_fraction);
      extrap_r <= extrap;
      k_lo_r   <= k_lo;
    end
  end

  // last + k * (last - prev), pinned to 65535 when out of 0..65535
  function automatic logic [DataW-1:0] extrapolate(input logic [DataW-1:0] last,
                                                   input logic [DataW-1:0] prev,
                                                   input logic [OctW-1:0]  k);
    logic signed [22:0] last_w;
    logic signed [22:0] step_w;
    logic signed [22:0] k_w;
    logic signed [22:0] v;
    last_w = $signed({7'b0, last});
    step_w = last_w - $signed({7'b0, prev});
    k_w    = $signed({19'b0, k});
    v      = last_w + step_w * k_w;
    if (v < 0 || v > 23'sd65535) begin
      return '1;
    end
    return v[DataW-1:0];
  endfunction

  // octave values and tuning sum
  logic [DataW-1:0] lo_r, lo_nxt;
  logic [DataW-1:0] hi_r, hi_nxt;
  logic [TuneW-1:0] tune_r, tune_nxt;

  always_comb begin
    if (extrap_r) begin
      lo_nxt = extrapolate(rd_b, rd_a, k_lo_r);
      hi_nxt = extrapolate(rd_b, rd_a, k_lo_r + OctW'(1));
    end else begin
      lo_nxt = rd_a;
      hi_nxt = rd_b;
    end
    tune_nxt = {1'b0, tune_q_r} + TuneW'(glide_r);
  end

  // interpolation multiply
  logic signed [TuneW-1:0] diff;
  logic signed [34:0]      prod;
  logic [DataW-1:0]        mid_r, mid_nxt;
  logic [DataW-1:0]        span_r, span_nxt;

  always_comb begin
    diff     = $signed({1'b0, hi_r}) - $signed({1'b0, lo_r});
    prod     = $signed({1'b0, tune_r}) * diff;
    mid_nxt  = prod[31:16];
    span_nxt = diff[DataW-1:0];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      tune_r <= tune_nxt;
    end
    if (state_r == S_MUL) begin
      mid_r  <= mid_nxt;
      span_r <= span_nxt;
    end
  end

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r;
  logic        out_load;

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmp_start) begin
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {span_r, lo_r + mid_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  a_compute_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_start |=> (state_r == S_READ))
    else $error("compute transfer did not start table read");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (op != OP_COMPUTE) && !out_tvalid) |=> !out_tvalid)
    else $error("table write produced a result");

  a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && (!out_tvalid || out_tready)) |=> (out_tvalid && (state_r == S_IDLE)))
    else $error("finished result not loaded into output register");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |=> !in_tready)
    else $error("input accepted while a conversion is in flight");

endmodule

`default_nettype wire

FILE: tb/note_to_cv_interpolator_unit_tb.sv
// ----------------------------------------------------------------------------
// note_to_cv_interpolator_unit_tb: self-checking bench for the note to CV unit
// Loads the calibration and tuning tables, runs corner cases and random
// write/compute traffic with random gaps on both streams, and checks each
// result against a local table-lookup interpolation predictor.
// ----------------------------------------------------------------------------
module note_to_cv_interpolator_unit_tb
  import ncvi_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int OCT_N       = 11;
  localparam int CHAN_N      = 18;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 20;
  localparam int LONG_HOLD   = 300;

  // opcode with no function, must be dropped
  localparam opcode_t OP_UNUSED = 2'd3;

  typedef struct packed {
    opcode_t          op;
    logic [ChanW-1:0] ch;
    logic [SlotW-1:0] slot;
    logic [PcW-1:0]   pc;
    logic [DataW-1:0] data;
    logic [NoteW-1:0] note;
    logic [FracW-1:0] frac;
  } note_item_t;

  typedef struct packed {
    logic [DataW-1:0] cv;
    logic [DataW-1:0] span;
  } cv_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  // predictor state
  logic [DataW-1:0] oct_cal [OCT_N][CHAN_N];
  logic [DataW-1:0] pc_tune [PITCH_CLASSES];
  cv_result_t       cv_expect_q [$];

  int          errors = 0;
  int unsigned cycle_count = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int          rx_hold_len = 0;

  note_to_cv_interpolator_unit #(
    .OCTAVE_COUNT (OCT_N),
    .CHANNEL_COUNT(CHAN_N)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---- predictor ----------------------------------------------------------

  // octave value with linear extrapolation above the table, clamped at 65535
  function automatic logic [DataW-1:0] octave_level(input int unsigned oct,
                                                    input int unsigned ch);
    logic [31:0] last, prev, step, v;
    if (ch >= CHAN_N) return '0;
    if (oct < OCT_N) return oct_cal[oct][ch];
    last = 32'(oct_cal[OCT_N-1][ch]);
    prev = 32'(oct_cal[OCT_N-2][ch]);
    step = last - prev;
    v = last + (oct - OCT_N + 1) * step;
    if (v > 32'd65535) v = 32'd65535;
    return v[DataW-1:0];
  endfunction

  function automatic cv_result_t interpolate_cv(input note_item_t it);
    int unsigned lo_oct;
    logic [31:0] lo, hi, tune, diff, prod, val;
    cv_result_t  r;
    lo_oct = it.note / PITCH_CLASSES;
    lo = 32'(octave_level(lo_oct, it.ch));
    hi = 32'(octave_level(lo_oct + 1, it.ch));
    tune = 32'(pc_tune[it.note % PITCH_CLASSES]) + ((32'(it.frac) << 8) / PITCH_CLASSES);
    diff = hi - lo;
    prod = tune * diff;
    val = lo + (prod >> 16);
    r.cv = val[DataW-1:0];
    r.span = diff[DataW-1:0];
    return r;
  endfunction

  // updates the tables or queues the expected control value
  task automatic model_item(input note_item_t it);
    case (it.op)
      OP_WR_OCTAVE: begin
        if (it.slot < OCT_N && it.ch < CHAN_N) oct_cal[it.slot][it.ch] = it.data;
      end
      OP_WR_TUNE: begin
        if (it.pc < PITCH_CLASSES) pc_tune[it.pc] = it.data;
      end
      OP_COMPUTE: cv_expect_q.push_back(interpolate_cv(it));
      default: ;
    endcase
  endtask

  // ---- stimulus helpers ---------------------------------------------------

  function automatic logic [DataW-1:0] rand_word();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return DataW'($urandom_range(0, 65535));
  endfunction

  // all fields random, so unused fields also toggle
  function automatic note_item_t noise_item(input opcode_t op);
    note_item_t  it;
    logic [63:0] bits;
    bits = {$urandom(), $urandom()};
    it = bits[$bits(note_item_t)-1:0];
    it.op = op;
    return it;
  endfunction

  function automatic note_item_t oct_write(input int unsigned slot, input int unsigned ch,
                                           input logic [DataW-1:0] data);
    note_item_t it;
    it = noise_item(OP_WR_OCTAVE);
    it.slot = SlotW'(slot);
    it.ch = ChanW'(ch);
    it.data = data;
    return it;
  endfunction

  function automatic note_item_t tune_write(input int unsigned pc,
                                            input logic [DataW-1:0] data);
    note_item_t it;
    it = noise_item(OP_WR_TUNE);
    it.pc = PcW'(pc);
    it.data = data;
    return it;
  endfunction

  function automatic note_item_t cv_request(input int unsigned note, input int unsigned ch,
                                            input int unsigned frac);
    note_item_t it;
    it = noise_item(OP_COMPUTE);
    it.note = NoteW'(note);
    it.ch = ChanW'(ch);
    it.frac = FracW'(frac);
    return it;
  endfunction

  // called just after a rising edge; returns just after the transfer edge
  task automatic push_item(input note_item_t it);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.op;
    in_tdata <= {4'b0, it.frac, it.note, it.data, it.pc, it.slot, it.ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    model_item(it);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (cv_expect_q.size() != 0) @(posedge clk);
  endtask

  // ---- result side --------------------------------------------------------

  initial begin
    int n;
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_len > 0) begin
        out_tready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold_len = 0;
      end
      n = rx_idle_on ? $urandom_range(0, 17) : 0;
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cv_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (cv_expect_q.size() == 0) begin
        $display("%0t: result with none pending, actual cv=%h span=%h",
                 $time, out_tdata[15:0], out_tdata[31:16]);
        errors++;
      end else begin
        want = cv_expect_q.pop_front();
        if (out_tdata[15:0] !== want.cv) begin
          $display("%0t: control_value expected %h actual %h",
                   $time, want.cv, out_tdata[15:0]);
          errors++;
        end
        if (out_tdata[31:16] !== want.span) begin
          $display("%0t: per_octave_span expected %h actual %h",
                   $time, want.span, out_tdata[31:16]);
          errors++;
        end
      end
    end
  end

  // ---- tests --------------------------------------------------------------

  // every octave entry and tuning entry written before any compute
  task automatic test_table_load();
    logic [DataW-1:0] lvl;
    for (int ch = 0; ch < CHAN_N; ch++) begin
      lvl = DataW'($urandom_range(0, 4000));
      for (int oct = 0; oct < OCT_N; oct++) begin
        // mostly rising curves, some channels fully random
        if (ch % 3 == 2) push_item(oct_write(oct, ch, rand_word()));
        else push_item(oct_write(oct, ch, lvl));
        lvl = lvl + DataW'($urandom_range(3000, 6000));
      end
    end
    for (int pc = 0; pc < PITCH_CLASSES; pc++)
      push_item(tune_write(pc, DataW'($urandom_range(0, 65535))));
  endtask

  task automatic test_corner_cases();
    push_item(tune_write(0, 16'h0000));
    push_item(tune_write(PITCH_CLASSES - 1, 16'hFFFF));
    // writes that must be dropped
    push_item(oct_write(15, 0, 16'hFFFF));
    push_item(oct_write(OCT_N, 3, 16'h1234));
    push_item(oct_write(0, 31, 16'hFFFF));
    push_item(oct_write(2, CHAN_N, 16'hABCD));
    push_item(tune_write(15, 16'hFFFF));
    push_item(tune_write(PITCH_CLASSES, 16'h5555));
    push_item(noise_item(OP_UNUSED));
    // note and fraction extremes
    push_item(cv_request(0, 0, 0));
    push_item(cv_request(127, CHAN_N - 1, 255));
    push_item(cv_request(11, 1, 255));
    push_item(cv_request(119, 5, 128));
    push_item(cv_request(120, 5, 0));
    // channel beyond the table reads zeros
    push_item(cv_request(60, CHAN_N, 77));
    push_item(cv_request(127, 31, 255));
    // falling top of table wraps negative and clamps
    push_item(oct_write(OCT_N - 1, 2, 16'd100));
    push_item(oct_write(OCT_N - 2, 2, 16'd5000));
    push_item(cv_request(127, 2, 255));
    // steep rise clamps at full scale
    push_item(oct_write(OCT_N - 1, 4, 16'hFFFF));
    push_item(oct_write(OCT_N - 2, 4, 16'h0000));
    push_item(cv_request(125, 4, 0));
    push_item(cv_request(119, 4, 255));
    drain_results();
  endtask

  task automatic test_random_traffic(input int count);
    int unsigned sel;
    note_item_t  it;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      // sender waits out everything in flight now and then
      if (i % 125 == 124) drain_results();
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        it = cv_request($urandom_range(0, 127),
                        ($urandom_range(0, 9) == 0) ? $urandom_range(CHAN_N, 31)
                                                    : $urandom_range(0, CHAN_N - 1),
                        $urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0) it.frac = '1;
      end else if (sel < 82) begin
        it = oct_write(($urandom_range(0, 7) == 0) ? $urandom_range(OCT_N, 15)
                                                   : $urandom_range(0, OCT_N - 1),
                       ($urandom_range(0, 7) == 0) ? $urandom_range(CHAN_N, 31)
                                                   : $urandom_range(0, CHAN_N - 1),
                       rand_word());
      end else if (sel < 96) begin
        it = tune_write(($urandom_range(0, 7) == 0) ? $urandom_range(PITCH_CLASSES, 15)
                                                    : $urandom_range(0, PITCH_CLASSES - 1),
                        rand_word());
      end else begin
        it = noise_item(OP_UNUSED);
      end
      push_item(it);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    drain_results();
  endtask

  // receiver stops for a long stretch while computes keep coming
  task automatic test_output_stall();
    tx_idle_on = 1'b0;
    rx_hold_len = LONG_HOLD;
    for (int i = 0; i < 40; i++)
      push_item(cv_request($urandom_range(0, 127), $urandom_range(0, CHAN_N - 1),
                           $urandom_range(0, 255)));
    tx_idle_on = 1'b1;
    drain_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_load();
    test_corner_cases();
    test_output_stall();
    test_random_traffic(480);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (cv_expect_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, cv_expect_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/ncvi_pkg.sv
design/ncvi_octave_mem.sv
design/note_to_cv_interpolator_unit.sv
tb/note_to_cv_interpolator_unit_tb.sv
